// ===== rtl/core/env_image_entry_scanner_macros.svh =====
// Assertion macros for the environment image entry scanner.
// Used by the top level only; no other dependencies.
`ifndef ENV_IMAGE_ENTRY_SCANNER_MACROS_SVH
`define ENV_IMAGE_ENTRY_SCANNER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk and disabled in reset.
`define EIES_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define EIES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EIES_ASSERT_IMPL(lbl, ante, cons, msg)
`define EIES_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/eies_pkg.sv =====
// Shared types and constants for the environment image entry scanner.
// No dependencies; imported by the front end, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package eies_pkg;

    // Result event codes.
    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_GOOD  = 3'd1;
    localparam logic [2:0] EV_BAD   = 3'd2;
    localparam logic [2:0] EV_END   = 3'd3;
    localparam logic [2:0] EV_TRUNC = 3'd4;

    // Reset value of the capacity register.
    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    // Characters with a role of their own.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;

    // Character class produced by the front end.
    typedef enum logic [2:0] {
        CLS_NUL,
        CLS_EQ,
        CLS_KEY,
        CLS_PRINT,
        CLS_OTHER
    } cls_t;

    // Input transaction.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } in_t;

    // Classified item passed from front to back.
    typedef struct packed {
        cls_t cls;
        logic restart;
    } mid_t;

    // Result transaction.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [15:0] pair_count;
        logic [15:0] bad_count;
        logic [15:0] position;
        logic        finished;
    } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/eies_fifo.sv =====
// Small synchronous FIFO used between the scanner stages and at the output.
// No package dependencies; DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module eies_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg, rd_ptr_next;
    logic             do_push, do_pop;

    // Status from the wrap bit and the index bits of the pointers.
    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                   (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    assign wr_ptr_next = do_push ? (wr_ptr_reg + (PTR_W+1)'(1)) : wr_ptr_reg;
    assign rd_ptr_next = do_pop  ? (rd_ptr_reg + (PTR_W+1)'(1)) : rd_ptr_reg;

    // The oldest entry is always presented at the read side.
    assign rd_data = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/eies_front.sv =====
// Front end of the scanner: accepts bytes and classifies each character.
// Depends on eies_pkg for the transaction and class types.
`timescale 1ns / 1ps
`default_nettype none

module eies_front (
    input  wire logic          push,
    input  wire eies_pkg::in_t item,
    output logic               full,
    input  wire logic          mid_full,
    output logic               mid_push,
    output eies_pkg::mid_t     mid_item
);

    import eies_pkg::*;

    logic [7:0] c;
    logic       is_digit, is_upper, is_lower, is_key, is_print;

    // The front stalls only when the queue to the back end is full.
    assign full     = mid_full;
    assign mid_push = push && !mid_full;

    // Character tests.
    assign c        = item.data_byte;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign is_upper = (c >= 8'h41) && (c <= 8'h5A);
    assign is_lower = (c >= 8'h61) && (c <= 8'h7A);
    assign is_key   = is_digit || is_upper || is_lower || (c == CHAR_UNDER);
    assign is_print = (c >= 8'h20) && (c <= 8'h7E);

    // Class priority: NUL, then '=', then key characters, then printable.
    always_comb
    begin
        mid_item.restart = item.restart;
        if (c == CHAR_NUL)
        begin
            mid_item.cls = CLS_NUL;
        end
        else if (c == CHAR_EQ)
        begin
            mid_item.cls = CLS_EQ;
        end
        else if (is_key)
        begin
            mid_item.cls = CLS_KEY;
        end
        else if (is_print)
        begin
            mid_item.cls = CLS_PRINT;
        end
        else
        begin
            mid_item.cls = CLS_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/eies_back.sv =====
// Back end of the scanner: entry state machine, counters and offset.
// Depends on eies_pkg for item types and event codes.
`timescale 1ns / 1ps
`default_nettype none

module eies_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [15:0]    capacity,
    input  wire logic           mid_empty,
    input  wire eies_pkg::mid_t mid_item,
    output logic                mid_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output eies_pkg::out_t      res_item
);

    import eies_pkg::*;

    typedef enum logic [1:0] {
        PH_START,
        PH_KEY,
        PH_VALUE,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_cur, phase_next;
    logic [15:0] offset_reg, offset_cur, offset_next;
    logic [15:0] good_reg, good_cur, good_next;
    logic [15:0] bad_reg, bad_cur, bad_next;
    logic        done_reg, done_cur, done_next;
    logic [2:0]  ev;
    logic        advance;
    logic        at_limit;

    // One item moves whenever there is one waiting and room for its result.
    assign mid_pop  = !mid_empty && !res_full;
    assign res_push = mid_pop;

    // A restart clears the scan state before the byte is examined.
    assign phase_cur  = mid_item.restart ? PH_START : phase_reg;
    assign offset_cur = mid_item.restart ? 16'd0 : offset_reg;
    assign good_cur   = mid_item.restart ? 16'd0 : good_reg;
    assign bad_cur    = mid_item.restart ? 16'd0 : bad_reg;
    assign done_cur   = mid_item.restart ? 1'b0 : done_reg;

    // Truncation when the offset of this byte reaches capacity minus one.
    assign at_limit = ({1'b0, offset_cur} + 17'd1) >= {1'b0, capacity};

    // Next scan state for the byte at the head of the queue.
    always_comb
    begin
        phase_next = phase_cur;
        good_next  = good_cur;
        bad_next   = bad_cur;
        done_next  = done_cur;
        ev         = EV_NONE;
        advance    = 1'b0;
        if (!done_cur)
        begin
            if (at_limit)
            begin
                ev        = EV_TRUNC;
                done_next = 1'b1;
            end
            else
            begin
                advance = 1'b1;
                unique case (phase_cur)
                    PH_START:
                    begin
                        case (mid_item.cls)
                            CLS_NUL:
                            begin
                                ev        = EV_END;
                                done_next = 1'b1;
                                advance   = 1'b0;
                            end
                            CLS_KEY: phase_next = PH_KEY;
                            default: phase_next = PH_SKIP;
                        endcase
                    end
                    PH_KEY:
                    begin
                        case (mid_item.cls)
                            CLS_NUL:
                            begin
                                ev         = EV_BAD;
                                bad_next   = (bad_cur == 16'hFFFF) ? bad_cur
                                                                   : bad_cur + 16'd1;
                                phase_next = PH_START;
                            end
                            CLS_EQ:  phase_next = PH_VALUE;
                            CLS_KEY: phase_next = PH_KEY;
                            default: phase_next = PH_SKIP;
                        endcase
                    end
                    PH_VALUE:
                    begin
                        case (mid_item.cls)
                            CLS_NUL:
                            begin
                                ev         = EV_GOOD;
                                good_next  = (good_cur == 16'hFFFF) ? good_cur
                                                                    : good_cur + 16'd1;
                                phase_next = PH_START;
                            end
                            CLS_EQ, CLS_KEY, CLS_PRINT: phase_next = PH_VALUE;
                            default: phase_next = PH_SKIP;
                        endcase
                    end
                    PH_SKIP:
                    begin
                        if (mid_item.cls == CLS_NUL)
                        begin
                            ev         = EV_BAD;
                            bad_next   = (bad_cur == 16'hFFFF) ? bad_cur
                                                               : bad_cur + 16'd1;
                            phase_next = PH_START;
                        end
                    end
                endcase
            end
        end
        offset_next = advance ? (offset_cur + 16'd1) : offset_cur;
    end

    // Result of this byte.
    always_comb
    begin
        res_item.event_res  = ev;
        res_item.pair_count = good_next;
        res_item.bad_count  = bad_next;
        res_item.position   = offset_cur;
        res_item.finished   = done_next;
    end

    // Scan state registers, updated once per transaction taken from the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            offset_reg <= 16'd0;
            good_reg   <= 16'd0;
            bad_reg    <= 16'd0;
            done_reg   <= 1'b0;
        end
        else if (mid_pop)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
            done_reg   <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/env_image_entry_scanner.sv =====
// Top level of the environment image entry scanner.
// Depends on eies_pkg, eies_front, eies_fifo, eies_back and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "env_image_entry_scanner_macros.svh"

// The scanner takes one byte of an environment image per transaction and returns
// one result per byte: the event the byte caused, the running pair and bad-entry
// counts, the byte's offset and the finished flag. It sustains one byte per clock
// cycle while the consumer keeps popping results. A byte is registered in the
// classification queue when it is accepted; the back end then scans it from there
// and writes its result, which the result ports present from the head of the
// result queue. The front end classifies each character and the back end runs the
// entry state machine, so either side can stall without stopping the other until
// the MID_DEPTH-entry queue between them or the RES_DEPTH-entry result queue fills.
// Write capacity only while no transactions are in flight.
module env_image_entry_scanner #(
    parameter int MID_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire eies_pkg::in_t  item,
    output logic                full,
    input  wire logic           pop,
    output eies_pkg::out_t      result,
    output logic                empty,
    input  wire logic           cfg_wr_en,
    input  wire logic [15:0]    cfg_wr_data
);

    import eies_pkg::*;

    localparam int MID_W = $bits(mid_t);
    localparam int RES_W = $bits(out_t);

    logic [15:0] capacity_reg;
    logic        mid_push, mid_full, mid_pop, mid_empty;
    mid_t        mid_wr_item, mid_rd_item;
    logic        res_push, res_full;
    out_t        res_item;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // Front end: accept and classify.
    eies_front u_front (
        .push     (push),
        .item     (item),
        .full     (full),
        .mid_full (mid_full),
        .mid_push (mid_push),
        .mid_item (mid_wr_item)
    );

    // Queue between classification and scanning.
    eies_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (mid_wr_item),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_rd_item),
        .empty   (mid_empty)
    );

    // Back end: entry state machine and counters.
    eies_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .mid_empty (mid_empty),
        .mid_item  (mid_rd_item),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_item)
    );

    // Result queue toward the consumer.
    eies_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_item),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

    // A closing event always comes with the finished flag set.
    `EIES_ASSERT_IMPL(a_end_finished,
        !empty && (result.event_res == EV_END || result.event_res == EV_TRUNC),
        result.finished, "end or truncation without finished")
    // A good pair result always carries a nonzero pair count.
    `EIES_ASSERT_IMPL(a_good_count, !empty && result.event_res == EV_GOOD,
        result.pair_count != 16'd0, "good pair with zero pair count")
    // A bad entry result always carries a nonzero bad count.
    `EIES_ASSERT_IMPL(a_bad_count, !empty && result.event_res == EV_BAD,
        result.bad_count != 16'd0, "bad entry with zero bad count")
    // A scanned item always lands in the result queue on the next cycle.
    `EIES_ASSERT_NEXT(a_res_filled, mid_pop, !empty, "scanned item missing from result queue")

endmodule

`default_nettype wire
